### hdl/tvr_pkg.sv
// Shared widths, types and codes of the triangle region closest-point pipeline.
package tvr_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DOT_W   = 2 * DIFF_W + 2;
    localparam int LO_W    = DOT_W / 2;
    localparam int HI_W    = DOT_W - LO_W;
    localparam int PH_W    = DOT_W + HI_W;
    localparam int PL_W    = DOT_W + LO_W + 1;
    localparam int TRIP_W  = 2 * DOT_W + 1;
    localparam int NUM_W   = DOT_W + DIFF_W;
    localparam int QUO_W   = COORD_W;
    localparam int SUM_W   = COORD_W + 2;

    localparam int FRONT_STAGES  = 2;
    localparam int REGION_STAGES = 3;
    localparam int DIV_STAGES    = QUO_W + 2;
    localparam int PIPE_DEPTH    = FRONT_STAGES + REGION_STAGES + DIV_STAGES;
    localparam int CNT_W         = $clog2(PIPE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_EDGE   = 2'd1,
        KIND_FACE   = 2'd2
    } t_kind;

    typedef logic [COORD_W-1:0]        t_coord;
    typedef t_coord [2:0]              t_cvec;
    typedef logic [DIFF_W-1:0]         t_diff;
    typedef t_diff [2:0]               t_dvec;
    typedef logic [DOT_W-1:0]          t_dot;
    typedef logic [NUM_W-1:0]          t_num;
    typedef logic [QUO_W-1:0]          t_quo;
    typedef logic [CNT_W-1:0]          t_cnt;

    typedef logic signed [DIFF_W-1:0]  t_sdiff;
    typedef logic signed [DOT_W-1:0]   t_sdot;
    typedef logic signed [PH_W-1:0]    t_sph;
    typedef logic signed [PL_W-1:0]    t_spl;
    typedef logic signed [TRIP_W-1:0]  t_strip;
    typedef logic signed [NUM_W-1:0]   t_snum;
    typedef logic signed [SUM_W-1:0]   t_ssum;

    // Differences and dot products of one query
    typedef struct packed {
        t_cvec [2:0] vert;
        t_cvec       qry;
        t_dvec [2:0] edg;
        t_dot  [2:0] m;
        t_dot  [2:0] n;
        t_dot  [2:0] dd;
        t_dot  [2:0] g;
    } t_front;

    // Region decision and projection numerators
    typedef struct packed {
        t_kind      kind;
        logic [1:0] idx;
        t_cvec      base;
        logic       div_en;
        t_dot       dd;
        t_num [2:0] num;
    } t_numer;

endpackage

### hdl/tvr_in_if.sv
// Query channel: three triangle vertices and a query point.
interface tvr_in_if;
    logic valid;
    logic ready;
    logic signed [tvr_pkg::COORD_W-1:0] vert_a_x;
    logic signed [tvr_pkg::COORD_W-1:0] vert_a_y;
    logic signed [tvr_pkg::COORD_W-1:0] vert_a_z;
    logic signed [tvr_pkg::COORD_W-1:0] vert_b_x;
    logic signed [tvr_pkg::COORD_W-1:0] vert_b_y;
    logic signed [tvr_pkg::COORD_W-1:0] vert_b_z;
    logic signed [tvr_pkg::COORD_W-1:0] vert_c_x;
    logic signed [tvr_pkg::COORD_W-1:0] vert_c_y;
    logic signed [tvr_pkg::COORD_W-1:0] vert_c_z;
    logic signed [tvr_pkg::COORD_W-1:0] query_x;
    logic signed [tvr_pkg::COORD_W-1:0] query_y;
    logic signed [tvr_pkg::COORD_W-1:0] query_z;

    modport source (
        output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
        output vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z,
        input  ready
    );
    modport sink (
        input  valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
        input  vert_c_x, vert_c_y, vert_c_z, query_x, query_y, query_z,
        output ready
    );
endinterface

### hdl/tvr_out_if.sv
// Result channel: region and closest point.
interface tvr_out_if;
    logic valid;
    logic ready;
    logic [1:0] region_kind;
    logic [1:0] region_index;
    logic signed [tvr_pkg::COORD_W-1:0] closest_x;
    logic signed [tvr_pkg::COORD_W-1:0] closest_y;
    logic signed [tvr_pkg::COORD_W-1:0] closest_z;

    modport source (
        output valid, region_kind, region_index, closest_x, closest_y, closest_z,
        input  ready
    );
    modport sink (
        input  valid, region_kind, region_index, closest_x, closest_y, closest_z,
        output ready
    );
endinterface

### hdl/tvr_front.sv
// Front stages: coordinate differences, then the twelve dot products.
module tvr_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    output logic                   o_rdy,
    input  tvr_pkg::t_cvec [2:0]   i_vert,
    input  tvr_pkg::t_cvec         i_qry,
    output logic                   o_vld,
    input  logic                   i_rdy,
    output tvr_pkg::t_front        o_data
);

    function automatic tvr_pkg::t_dot dot3(input tvr_pkg::t_dvec a, input tvr_pkg::t_dvec b);
        tvr_pkg::t_sdot s;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            s = s + tvr_pkg::t_sdot'($signed(a[k])) * tvr_pkg::t_sdot'($signed(b[k]));
        end
        return tvr_pkg::t_dot'(s);
    endfunction

    logic adv1, adv2;
    logic r_vld1, r_vld2;

    tvr_pkg::t_dvec [2:0] n_ax1, n_e1, r_ax1, r_e1, r_e2;
    tvr_pkg::t_cvec [2:0] r_vert1, r_vert2;
    tvr_pkg::t_cvec       r_qry1, r_qry2;
    tvr_pkg::t_dot  [2:0] n_m2, n_n2, n_dd2, n_g2, r_m2, r_n2, r_dd2, r_g2;

    assign adv2  = !r_vld2 || i_rdy;
    assign adv1  = !r_vld1 || adv2;
    assign o_rdy = adv1;

    // ax[i] = v[i] - p, e[i] = v[i+1] - v[i]
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_ax1[i][k] = tvr_pkg::t_diff'(tvr_pkg::t_sdiff'($signed(i_vert[i][k]))
                            - tvr_pkg::t_sdiff'($signed(i_qry[k])));
                n_e1[i][k]  = tvr_pkg::t_diff'(tvr_pkg::t_sdiff'($signed(i_vert[(i + 1) % 3][k]))
                            - tvr_pkg::t_sdiff'($signed(i_vert[i][k])));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_m2[i]  = dot3(r_ax1[i], r_e1[i]);
            n_n2[i]  = dot3(r_ax1[i], r_e1[(i + 2) % 3]);
            n_dd2[i] = dot3(r_e1[i], r_e1[i]);
            n_g2[i]  = dot3(r_e1[(i + 1) % 3], r_e1[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (adv1) r_vld1 <= i_vld;
            if (adv2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_ax1   <= n_ax1;
            r_e1    <= n_e1;
            r_vert1 <= i_vert;
            r_qry1  <= i_qry;
        end
        if (adv2) begin
            r_m2    <= n_m2;
            r_n2    <= n_n2;
            r_dd2   <= n_dd2;
            r_g2    <= n_g2;
            r_e2    <= r_e1;
            r_vert2 <= r_vert1;
            r_qry2  <= r_qry1;
        end
    end

    assign o_vld       = r_vld2;
    assign o_data.vert = r_vert2;
    assign o_data.qry  = r_qry2;
    assign o_data.edg  = r_e2;
    assign o_data.m    = r_m2;
    assign o_data.n    = r_n2;
    assign o_data.dd   = r_dd2;
    assign o_data.g    = r_g2;

endmodule

### hdl/tvr_region.sv
// Region stages: triple-product partials, region decision, projection numerators.
module tvr_region (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  tvr_pkg::t_front  i_data,
    output logic             o_vld,
    input  logic             i_rdy,
    output tvr_pkg::t_numer  o_data
);

    logic adv3, adv4, adv5;
    logic r_vld3, r_vld4, r_vld5;

    // stage 3
    logic [2:0][tvr_pkg::PH_W-1:0] n_ph1, n_ph2, r_ph1, r_ph2;
    logic [2:0][tvr_pkg::PL_W-1:0] n_pl1, n_pl2, r_pl1, r_pl2;
    logic [2:0]                    n_vtx, n_epre, r_vtx3, r_epre3;
    tvr_pkg::t_cvec [2:0]          r_vert3;
    tvr_pkg::t_cvec                r_qry3;
    tvr_pkg::t_dvec [2:0]          r_edg3;
    tvr_pkg::t_dot  [2:0]          r_m3, r_dd3;

    // stage 4
    tvr_pkg::t_kind n_kind4, r_kind4;
    logic [1:0]     n_idx4, r_idx4;
    tvr_pkg::t_cvec n_base4, r_base4;
    tvr_pkg::t_dot  n_t4, r_t4, n_dd4, r_dd4;
    tvr_pkg::t_dvec n_d4, r_d4;
    logic           n_div_en4, r_div_en4;

    // stage 5
    tvr_pkg::t_num [2:0] n_num5, r_num5;
    tvr_pkg::t_kind      r_kind5;
    logic [1:0]          r_idx5;
    tvr_pkg::t_cvec      r_base5;
    tvr_pkg::t_dot       r_dd5;
    logic                r_div_en5;

    assign adv5  = !r_vld5 || i_rdy;
    assign adv4  = !r_vld4 || adv5;
    assign adv3  = !r_vld3 || adv4;
    assign o_rdy = adv3;

    // trip[i] = m[i+1]*dd[i] - n[i+1]*g[i], second factor split in halves
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_ph1[i] = tvr_pkg::t_sph'($signed(i_data.m[(i + 1) % 3]))
                     * tvr_pkg::t_sph'($signed(i_data.dd[i][tvr_pkg::DOT_W-1:tvr_pkg::LO_W]));
            n_pl1[i] = tvr_pkg::t_spl'($signed(i_data.m[(i + 1) % 3]))
                     * tvr_pkg::t_spl'({1'b0, i_data.dd[i][tvr_pkg::LO_W-1:0]});
            n_ph2[i] = tvr_pkg::t_sph'($signed(i_data.n[(i + 1) % 3]))
                     * tvr_pkg::t_sph'($signed(i_data.g[i][tvr_pkg::DOT_W-1:tvr_pkg::LO_W]));
            n_pl2[i] = tvr_pkg::t_spl'($signed(i_data.n[(i + 1) % 3]))
                     * tvr_pkg::t_spl'({1'b0, i_data.g[i][tvr_pkg::LO_W-1:0]});
            n_vtx[i]  = !i_data.m[i][tvr_pkg::DOT_W-1]
                     && (i_data.n[i][tvr_pkg::DOT_W-1] || i_data.n[i] == '0);
            n_epre[i] = (i_data.m[i][tvr_pkg::DOT_W-1] || i_data.m[i] == '0)
                     && !i_data.n[(i + 1) % 3][tvr_pkg::DOT_W-1];
        end
    end

    // first matching test wins: vertices, then edges, then face
    always_comb begin
        tvr_pkg::t_strip trip;
        logic            found;
        found     = 1'b0;
        n_kind4   = tvr_pkg::KIND_FACE;
        n_idx4    = '0;
        n_base4   = r_qry3;
        n_t4      = '0;
        n_d4      = '0;
        n_dd4     = '0;
        for (int i = 0; i < 3; i++) begin
            if (!found && r_vtx3[i]) begin
                found   = 1'b1;
                n_kind4 = tvr_pkg::KIND_VERTEX;
                n_idx4  = 2'(i);
                n_base4 = r_vert3[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            trip = (tvr_pkg::t_strip'($signed(r_ph1[i])) <<< tvr_pkg::LO_W)
                 + tvr_pkg::t_strip'($signed(r_pl1[i]))
                 - (tvr_pkg::t_strip'($signed(r_ph2[i])) <<< tvr_pkg::LO_W)
                 - tvr_pkg::t_strip'($signed(r_pl2[i]));
            if (!found && r_epre3[i] && !trip[tvr_pkg::TRIP_W-1]) begin
                found   = 1'b1;
                n_kind4 = tvr_pkg::KIND_EDGE;
                n_idx4  = 2'(i);
                n_base4 = r_vert3[i];
                n_t4    = -r_m3[i];
                n_d4    = r_edg3[i];
                n_dd4   = r_dd3[i];
            end
        end
        n_div_en4 = (n_kind4 == tvr_pkg::KIND_EDGE) && (n_dd4 != '0);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_num5[k] = tvr_pkg::t_num'(tvr_pkg::t_snum'($signed(r_t4))
                      * tvr_pkg::t_snum'($signed(r_d4[k])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (adv3) r_vld3 <= i_vld;
            if (adv4) r_vld4 <= r_vld3;
            if (adv5) r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_ph1   <= n_ph1;
            r_pl1   <= n_pl1;
            r_ph2   <= n_ph2;
            r_pl2   <= n_pl2;
            r_vtx3  <= n_vtx;
            r_epre3 <= n_epre;
            r_vert3 <= i_data.vert;
            r_qry3  <= i_data.qry;
            r_edg3  <= i_data.edg;
            r_m3    <= i_data.m;
            r_dd3   <= i_data.dd;
        end
        if (adv4) begin
            r_kind4   <= n_kind4;
            r_idx4    <= n_idx4;
            r_base4   <= n_base4;
            r_t4      <= n_t4;
            r_d4      <= n_d4;
            r_dd4     <= n_dd4;
            r_div_en4 <= n_div_en4;
        end
        if (adv5) begin
            r_num5    <= n_num5;
            r_kind5   <= r_kind4;
            r_idx5    <= r_idx4;
            r_base5   <= r_base4;
            r_dd5     <= r_dd4;
            r_div_en5 <= r_div_en4;
        end
    end

    assign o_vld         = r_vld5;
    assign o_data.kind   = r_kind5;
    assign o_data.idx    = r_idx5;
    assign o_data.base   = r_base5;
    assign o_data.div_en = r_div_en5;
    assign o_data.dd     = r_dd5;
    assign o_data.num    = r_num5;

endmodule

### hdl/tvr_divide.sv
// Divide stages: magnitude, one quotient bit per stage, sign, add and saturate.
module tvr_divide (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  tvr_pkg::t_numer  i_data,
    output logic             o_vld,
    input  logic             i_rdy,
    output tvr_pkg::t_kind   o_kind,
    output logic [1:0]       o_idx,
    output tvr_pkg::t_cvec   o_pt
);

    logic [tvr_pkg::DIV_STAGES-1:0] adv, r_vld;

    tvr_pkg::t_kind      r_kind   [0:tvr_pkg::QUO_W];
    logic [1:0]          r_idx    [0:tvr_pkg::QUO_W];
    tvr_pkg::t_cvec      r_base   [0:tvr_pkg::QUO_W];
    logic                r_div_en [0:tvr_pkg::QUO_W];
    logic [2:0]          r_neg    [0:tvr_pkg::QUO_W];
    tvr_pkg::t_dot       r_dd     [0:tvr_pkg::QUO_W];
    tvr_pkg::t_num [2:0] n_rem    [0:tvr_pkg::QUO_W];
    tvr_pkg::t_num [2:0] r_rem    [0:tvr_pkg::QUO_W];
    tvr_pkg::t_quo [2:0] n_quo    [0:tvr_pkg::QUO_W];
    tvr_pkg::t_quo [2:0] r_quo    [0:tvr_pkg::QUO_W];
    logic [2:0]          n_neg;

    tvr_pkg::t_cvec      n_out_pt, r_out_pt;
    tvr_pkg::t_kind      r_out_kind;
    logic [1:0]          r_out_idx;

    always_comb begin
        adv[tvr_pkg::DIV_STAGES-1] = !r_vld[tvr_pkg::DIV_STAGES-1] || i_rdy;
        for (int s = tvr_pkg::DIV_STAGES - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end
    assign o_rdy = adv[0];

    // restoring division; the edge test bounds the quotient below 2**QUO_W
    always_comb begin
        tvr_pkg::t_num trial;
        logic          ge;
        for (int k = 0; k < 3; k++) begin
            n_neg[k]    = i_data.num[k][tvr_pkg::NUM_W-1];
            n_rem[0][k] = n_neg[k] ? -i_data.num[k] : i_data.num[k];
            n_quo[0][k] = '0;
        end
        for (int s = 1; s <= tvr_pkg::QUO_W; s++) begin
            for (int k = 0; k < 3; k++) begin
                trial       = tvr_pkg::t_num'(r_dd[s-1]) << (tvr_pkg::QUO_W - s);
                ge          = r_rem[s-1][k] >= trial;
                n_rem[s][k] = ge ? r_rem[s-1][k] - trial : r_rem[s-1][k];
                n_quo[s][k] = r_quo[s-1][k]
                            | (ge ? tvr_pkg::t_quo'(1) << (tvr_pkg::QUO_W - s) : '0);
            end
        end
    end

    always_comb begin
        tvr_pkg::t_ssum q;
        tvr_pkg::t_ssum sum;
        for (int k = 0; k < 3; k++) begin
            q   = tvr_pkg::t_ssum'(r_quo[tvr_pkg::QUO_W][k]);
            q   = r_neg[tvr_pkg::QUO_W][k] ? -q : q;
            sum = tvr_pkg::t_ssum'($signed(r_base[tvr_pkg::QUO_W][k])) + q;
            if (!r_div_en[tvr_pkg::QUO_W]) begin
                n_out_pt[k] = r_base[tvr_pkg::QUO_W][k];
            end else if ((&sum[tvr_pkg::SUM_W-1:tvr_pkg::COORD_W-1])
                      || !(|sum[tvr_pkg::SUM_W-1:tvr_pkg::COORD_W-1])) begin
                n_out_pt[k] = sum[tvr_pkg::COORD_W-1:0];
            end else if (sum[tvr_pkg::SUM_W-1]) begin
                n_out_pt[k] = {1'b1, {(tvr_pkg::COORD_W-1){1'b0}}};
            end else begin
                n_out_pt[k] = {1'b0, {(tvr_pkg::COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            for (int s = 1; s < tvr_pkg::DIV_STAGES; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_kind[0]   <= i_data.kind;
            r_idx[0]    <= i_data.idx;
            r_base[0]   <= i_data.base;
            r_div_en[0] <= i_data.div_en;
            r_neg[0]    <= n_neg;
            r_dd[0]     <= i_data.dd;
            r_rem[0]    <= n_rem[0];
            r_quo[0]    <= n_quo[0];
        end
        for (int s = 1; s <= tvr_pkg::QUO_W; s++) begin
            if (adv[s]) begin
                r_kind[s]   <= r_kind[s-1];
                r_idx[s]    <= r_idx[s-1];
                r_base[s]   <= r_base[s-1];
                r_div_en[s] <= r_div_en[s-1];
                r_neg[s]    <= r_neg[s-1];
                r_dd[s]     <= r_dd[s-1];
                r_rem[s]    <= n_rem[s];
                r_quo[s]    <= n_quo[s];
            end
        end
        if (adv[tvr_pkg::DIV_STAGES-1]) begin
            r_out_kind <= r_kind[tvr_pkg::QUO_W];
            r_out_idx  <= r_idx[tvr_pkg::QUO_W];
            r_out_pt   <= n_out_pt;
        end
    end

    assign o_vld  = r_vld[tvr_pkg::DIV_STAGES-1];
    assign o_kind = r_out_kind;
    assign o_idx  = r_out_idx;
    assign o_pt   = r_out_pt;

endmodule

### hdl/triangle_voronoi_region_closest_point_core.sv
// Top level of the triangle region closest-point pipeline.
//
//   channel  | dir | handshake      | beat
//   ---------+-----+----------------+----------------------------------------
//   i_in     | in  | valid / ready  | vertices a, b, c and query point, Q8.8
//   o_out    | out | valid / ready  | region kind, region index, closest point
//
// One beat enters per cycle while o_out is not stalled; each result passes through
// 2 front, 3 region, 1 magnitude, 16 divider bit stages and 1 output stage.
// Latency is set by the bit-per-stage divider of the edge projection.
// Reset clears the stage valid bits and the in-flight beat counter only; no data lives between beats.
// A stall at o_out holds the last stage; earlier stages keep filling bubbles,
// so i_in.ready drops only when every stage holds a beat.
module triangle_voronoi_region_closest_point_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tvr_in_if.sink    i_in,
    tvr_out_if.source o_out
);

    tvr_pkg::t_cvec [2:0] vert;
    tvr_pkg::t_cvec       qry;

    logic             front_vld, region_rdy;
    tvr_pkg::t_front  front_data;
    logic             numer_vld, div_rdy;
    tvr_pkg::t_numer  numer_data;

    logic             res_vld;
    tvr_pkg::t_kind   res_kind;
    logic [1:0]       res_idx;
    tvr_pkg::t_cvec   res_pt;

    tvr_pkg::t_cnt    n_cnt, r_cnt;

    assign vert[0] = {i_in.vert_a_z, i_in.vert_a_y, i_in.vert_a_x};
    assign vert[1] = {i_in.vert_b_z, i_in.vert_b_y, i_in.vert_b_x};
    assign vert[2] = {i_in.vert_c_z, i_in.vert_c_y, i_in.vert_c_x};
    assign qry     = {i_in.query_z, i_in.query_y, i_in.query_x};

    tvr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_vert  (vert),
        .i_qry   (qry),
        .o_vld   (front_vld),
        .i_rdy   (region_rdy),
        .o_data  (front_data)
    );

    tvr_region u_region (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .o_rdy   (region_rdy),
        .i_data  (front_data),
        .o_vld   (numer_vld),
        .i_rdy   (div_rdy),
        .o_data  (numer_data)
    );

    tvr_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (numer_vld),
        .o_rdy   (div_rdy),
        .i_data  (numer_data),
        .o_vld   (res_vld),
        .i_rdy   (o_out.ready),
        .o_kind  (res_kind),
        .o_idx   (res_idx),
        .o_pt    (res_pt)
    );

    assign o_out.valid        = res_vld;
    assign o_out.region_kind  = res_kind;
    assign o_out.region_index = res_idx;
    assign o_out.closest_x    = $signed(res_pt[0]);
    assign o_out.closest_y    = $signed(res_pt[1]);
    assign o_out.closest_z    = $signed(res_pt[2]);

    // beats in flight
    assign n_cnt = r_cnt + tvr_pkg::t_cnt'(i_in.valid && i_in.ready)
                 - tvr_pkg::t_cnt'(o_out.valid && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tvr_pkg::t_cnt'(tvr_pkg::PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_cnt != '0)
        else $error("result shown with no query in flight");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_cnt != '0)
        else $error("input stalled while pipeline empty");

    a_face_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.region_kind == tvr_pkg::KIND_FACE) |->
        o_out.region_index == 2'd0)
        else $error("face region with nonzero index");

endmodule

### test/triangle_voronoi_region_closest_point_core_tb.sv
// Self-checking testbench of the triangle region closest-point core.
`timescale 1ns / 1ps

module triangle_voronoi_region_closest_point_core_tb;

    typedef logic signed [tvr_pkg::COORD_W-1:0] t_c;

    typedef struct {
        t_c v[3][3];
        t_c q[3];
    } t_query;

    typedef struct {
        tvr_pkg::t_kind kind;
        logic [1:0] idx;
        t_c pt[3];
    } t_region;

    // Wide signed math: 17-bit diffs, dots ~36 bits, triple products ~73 bits
    typedef logic signed [159:0] t_w;

    function automatic t_w dot3(t_w a[3], t_w b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic t_region closest_region(t_query x);
        t_region r;
        t_w vv[3][3], p[3], ax[3], ab[3], ac[3], bc[3], ba[3], bx[3], ps[3];
        t_w trip, dd, t, num, quo, sum;
        int s, e, o;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) vv[i][k] = x.v[i][k];
            p[i] = x.q[i];
        end
        r.kind = tvr_pkg::KIND_FACE;
        r.idx = 2'd0;
        for (int k = 0; k < 3; k++) r.pt[k] = x.q[k];
        for (int i = 0; i < 3 && r.kind == tvr_pkg::KIND_FACE; i++) begin
            for (int k = 0; k < 3; k++) begin
                ax[k] = vv[i][k] - p[k];
                ab[k] = vv[i][k] - vv[(i + 1) % 3][k];
                ac[k] = vv[i][k] - vv[(i + 2) % 3][k];
            end
            if (dot3(ax, ab) <= 0 && dot3(ax, ac) <= 0) begin
                r.kind = tvr_pkg::KIND_VERTEX;
                r.idx = 2'(i);
                for (int k = 0; k < 3; k++) r.pt[k] = x.v[i][k];
            end
        end
        for (int i = 0; i < 3 && r.kind == tvr_pkg::KIND_FACE; i++) begin
            s = i; e = (i + 1) % 3; o = (i + 2) % 3;
            for (int k = 0; k < 3; k++) begin
                bc[k] = vv[e][k] - vv[o][k];
                ba[k] = vv[e][k] - vv[s][k];
                bx[k] = vv[e][k] - p[k];
                ax[k] = vv[s][k] - p[k];
                ab[k] = vv[s][k] - vv[e][k];
                ps[k] = p[k] - vv[s][k];
            end
            dd = dot3(ba, ba);
            trip = dot3(ba, bx) * dot3(bc, ba) - dot3(bc, bx) * dd;
            if (trip >= 0 && dot3(ax, ab) >= 0 && dot3(bx, ba) >= 0) begin
                r.kind = tvr_pkg::KIND_EDGE;
                r.idx = 2'(i);
                t = dot3(ps, ba);
                for (int k = 0; k < 3; k++) begin
                    if (dd == 0) begin
                        r.pt[k] = x.v[s][k];
                    end else begin
                        num = t * ba[k];
                        quo = num / dd;  // truncates toward zero
                        sum = vv[s][k] + quo;
                        if (sum < -32768) r.pt[k] = t_c'(-32768);
                        else if (sum > 32767) r.pt[k] = t_c'(32767);
                        else r.pt[k] = t_c'(sum);
                    end
                end
            end
        end
        return r;
    endfunction

    class region_scoreboard;
        t_region pending[$];
        int errors;

        function void note_query(t_query x);
            pending.insert(pending.size(), closest_region(x));
        endfunction

        function void check_result(tvr_pkg::t_kind kind, logic [1:0] idx,
                                   t_c cx, t_c cy, t_c cz);
            t_region w;
            if (pending.size() == 0) begin
                $error("result beat with no query pending");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (kind !== w.kind) begin
                $error("region_kind exp %0d got %0d", w.kind, kind); errors++;
            end
            if (idx !== w.idx) begin
                $error("region_index exp %0d got %0d", w.idx, idx); errors++;
            end
            if (cx !== w.pt[0]) begin
                $error("closest_x exp %0d got %0d", w.pt[0], cx); errors++;
            end
            if (cy !== w.pt[1]) begin
                $error("closest_y exp %0d got %0d", w.pt[1], cy); errors++;
            end
            if (cz !== w.pt[2]) begin
                $error("closest_z exp %0d got %0d", w.pt[2], cz); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    tvr_in_if  qry_ch();
    tvr_out_if res_ch();

    region_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;

    triangle_voronoi_region_closest_point_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(qry_ch.sink), .o_out(res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: random stall at the falling edge, check at the rising edge
    always @(negedge i_clk) res_ch.ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(tvr_pkg::t_kind'(res_ch.region_kind), res_ch.region_index,
                            res_ch.closest_x, res_ch.closest_y, res_ch.closest_z);
    end

    task automatic send_query(t_query x);
        while ($urandom_range(99) < send_idle) begin
            qry_ch.valid <= 0;
            @(negedge i_clk);
        end
        qry_ch.valid <= 1;
        {qry_ch.vert_a_x, qry_ch.vert_a_y, qry_ch.vert_a_z} <= {x.v[0][0], x.v[0][1], x.v[0][2]};
        {qry_ch.vert_b_x, qry_ch.vert_b_y, qry_ch.vert_b_z} <= {x.v[1][0], x.v[1][1], x.v[1][2]};
        {qry_ch.vert_c_x, qry_ch.vert_c_y, qry_ch.vert_c_z} <= {x.v[2][0], x.v[2][1], x.v[2][2]};
        {qry_ch.query_x, qry_ch.query_y, qry_ch.query_z} <= {x.q[0], x.q[1], x.q[2]};
        @(posedge i_clk);
        while (!qry_ch.ready) @(posedge i_clk);
        sb.note_query(x);
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        qry_ch.valid <= 0;
        @(negedge i_clk);
    endtask

    function automatic t_c rand_coord(int span);
        case ($urandom_range(9))
            0: return t_c'($urandom);
            1: return ($urandom_range(1)) ? t_c'(16'sh7fff) : t_c'(16'sh8000);
            default: return t_c'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic t_query rand_query();
        t_query x;
        int span;
        span = ($urandom_range(3) == 0) ? 32767 : 2048;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) x.v[i][k] = rand_coord(span);
            x.q[i] = rand_coord(span);
        end
        // Collapse an edge or put the point on the triangle now and then
        case ($urandom_range(7))
            0: x.v[1] = x.v[0];
            1: x.v[2] = x.v[$urandom_range(1)];
            2: for (int k = 0; k < 3; k++)
                   x.q[k] = t_c'((int'(x.v[0][k]) + int'(x.v[1][k]) + int'(x.v[2][k])) / 3);
            3: for (int k = 0; k < 3; k++)
                   x.q[k] = t_c'((int'(x.v[1][k]) + int'(x.v[2][k])) / 2);
            default: ;
        endcase
        return x;
    endfunction

    function automatic t_query make_query(int ax, int ay, int az, int bx, int by, int bz,
                                          int cx, int cy, int cz, int px, int py, int pz);
        t_query x;
        x.v[0] = '{t_c'(ax), t_c'(ay), t_c'(az)};
        x.v[1] = '{t_c'(bx), t_c'(by), t_c'(bz)};
        x.v[2] = '{t_c'(cx), t_c'(cy), t_c'(cz)};
        x.q    = '{t_c'(px), t_c'(py), t_c'(pz)};
        return x;
    endfunction

    task automatic run_phase(int n, int s_idle, int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int j = 0; j < n; j++) send_query(rand_query());
    endtask

    initial begin
        t_query d[$];
        qry_ch.valid = 0;
        {qry_ch.vert_a_x, qry_ch.vert_a_y, qry_ch.vert_a_z} = '0;
        {qry_ch.vert_b_x, qry_ch.vert_b_y, qry_ch.vert_b_z} = '0;
        {qry_ch.vert_c_x, qry_ch.vert_c_y, qry_ch.vert_c_z} = '0;
        {qry_ch.query_x, qry_ch.query_y, qry_ch.query_z} = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Vertex, edge and face regions of a plain triangle in z = 0, then other, degenerate and extreme triangles
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, -256, -256, 0));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 3000, -10, 0));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, -10, 3000, 77));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 1280, -512, 0));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 2000, 2000, 5));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, -512, 1280, 0));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 512, 512, 0));
        d.insert(d.size(), make_query(0, 0, 0, 2560, 0, 0, 0, 2560, 0, 512, 512, 300));
        d.insert(d.size(), make_query(0, 0, 0, 256, 256, 0, 0, 768, 5, 130, 1, -3));
        d.insert(d.size(), make_query(7, 7, 7, 7, 7, 7, 7, 7, 7, 100, -100, 3));
        d.insert(d.size(), make_query(0, 0, 0, 0, 0, 0, 500, 0, 0, 250, 300, 0));
        d.insert(d.size(), make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                                      -32768, 32767, 0, 32767, -32768, 32767));
        d.insert(d.size(), make_query(32767, 32767, 32767, -32768, -32768, -32768,
                                      32767, -32768, 32767, 0, 0, 0));
        d.insert(d.size(), make_query(-32768, 0, 0, 32767, 0, 0,
                                      0, 32767, 0, 0, -32768, -32768));
        d.insert(d.size(), make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        d.insert(d.size(), make_query(0, 0, 0, 100, 0, 0, 200, 0, 0, 150, 50, 0));
        send_idle = 0;
        foreach (d[j]) send_query(d[j]);

        run_phase(150, 18, 56);
        // Drain fully before resuming
        end_burst();
        while (sb.pending.size() != 0) @(negedge i_clk);
        run_phase(150, 56, 18);
        run_phase(150, 0, 0);
        end_burst();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end
endmodule
